// ===== design/pse_pkg.sv =====
// shared types and constants of the png stored stream encoder
// used by pse_front, pse_queue, pse_back and png_stored_stream_encoder
// no dependencies
package pse_pkg;

  // widths of the image size registers and counters
  localparam int DIM_W = 14;
  localparam int PIX_W = 24;

  // parameter defaults
  localparam int MAX_WIDTH_DEF = 8192;
  localparam int MAX_HEIGHT_DEF = 8192;
  localparam int STORED_BLOCK_MAX_DEF = 65535;

  // size after reset
  localparam logic [DIM_W-1:0] WIDTH_RESET = 14'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd240;

  // register indexes
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // classified pixel as handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic sof;  // first pixel of a frame
    logic sor;  // first pixel of a row
    logic eof;  // last pixel of a frame
  } item_t;

  // image size of the current frame
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

endpackage

// ===== design/pse_queue.sv =====
// small first-in first-out queue of classified pixels
// depends on pse_pkg (item_t)
module pse_queue #(
  parameter int DEPTH = pse_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pse_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output pse_pkg::item_t dout,
  output logic           empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pse_pkg::item_t  slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== design/pse_front.sv =====
// front of the encoder: size registers, pixel position, classification
// depends on pse_pkg (item_t, dims_t, constants)
module pse_front #(
  parameter int MAX_WIDTH = pse_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pse_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [pse_pkg::DIM_W-1:0]  wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pse_pkg::PIX_W-1:0]  in_pixel,
  input  logic                       q_full,
  output logic                       q_push,
  output pse_pkg::item_t             q_item,
  output pse_pkg::dims_t             dims
);
  localparam logic [pse_pkg::DIM_W-1:0] W_MAX = pse_pkg::DIM_W'(MAX_WIDTH);
  localparam logic [pse_pkg::DIM_W-1:0] H_MAX = pse_pkg::DIM_W'(MAX_HEIGHT);

  logic [pse_pkg::DIM_W-1:0] width;
  logic [pse_pkg::DIM_W-1:0] height;
  logic [pse_pkg::DIM_W-1:0] col;
  logic [pse_pkg::DIM_W-1:0] row;
  logic                      active;
  logic [pse_pkg::DIM_W-1:0] wr_val;
  logic                      accept;
  logic                      last_col;
  logic                      last_row;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign dims     = '{width: width, height: height};
  assign last_col = (col == width - 1'b1);
  assign last_row = (row == height - 1'b1);

  // zero written reads as one
  assign wr_val = (wr_data == '0) ? pse_pkg::DIM_W'(1) : wr_data;

  // size registers, frozen while a frame runs
  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= pse_pkg::WIDTH_RESET;
      height <= pse_pkg::HEIGHT_RESET;
    end else if (wr_en && !active) begin
      unique case (wr_index)
        pse_pkg::REG_WIDTH:  width  <= (wr_val > W_MAX) ? W_MAX : wr_val;
        pse_pkg::REG_HEIGHT: height <= (wr_val > H_MAX) ? H_MAX : wr_val;
        default: ;
      endcase
    end
  end

  // classify the accepted pixel
  assign q_push = accept;
  always_comb begin
    q_item.pixel = in_pixel;
    q_item.sof   = !active;
    q_item.sor   = (col == '0);
    q_item.eof   = last_col && last_row;
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      active <= 1'b0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row    <= '0;
          active <= 1'b0;
        end else begin
          row    <= row + 1'b1;
          active <= 1'b1;
        end
      end else begin
        col    <= col + 1'b1;
        active <= 1'b1;
      end
    end
  end
endmodule

// ===== design/pse_back.sv =====
// back of the encoder: byte sequencer with crc-32, adler-32 and block headers
// depends on pse_pkg (item_t, dims_t)
module pse_back #(
  parameter int STORED_BLOCK_MAX = pse_pkg::STORED_BLOCK_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pse_pkg::dims_t dims,
  input  logic           q_empty,
  input  pse_pkg::item_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  localparam logic [15:0] BLK_MAX = 16'(STORED_BLOCK_MAX);
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  // reciprocal of the block size, exact for dividends below 2^29
  localparam int RECIP_SHIFT = 45;
  localparam logic [45:0] BLK_RECIP = 46'((64'd1 << RECIP_SHIFT) / STORED_BLOCK_MAX + 1);
  // most bytes one pixel may send
  localparam logic [5:0] ITEM_BYTES_MAX = 6'd52;

  // byte positions in the header and trailer
  localparam logic [5:0] HDR_IHDR = 6'd12;
  localparam logic [5:0] HDR_IHDR_END = 6'd28;
  localparam logic [5:0] HDR_CRC = 6'd29;
  localparam logic [5:0] HDR_LEN = 6'd33;
  localparam logic [5:0] HDR_IDAT = 6'd37;
  localparam logic [5:0] HDR_LAST = 6'd42;
  localparam logic [5:0] HDR_INIT = 6'd1;
  localparam logic [5:0] BLK_LAST = 6'd4;
  localparam logic [5:0] TRL_CRC = 6'd4;
  localparam logic [5:0] TRL_LAST = 6'd19;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_RAW  = 5'b00100,
    S_BLK  = 5'b01000,
    S_TRL  = 5'b10000
  } state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  state_t          state;
  state_t          state_next;
  pse_pkg::item_t  cur;
  logic [5:0]      idx;
  logic [5:0]      idx_next;
  logic [1:0]      raw_idx;
  logic [1:0]      raw_idx_next;
  logic [15:0]     blk_left;
  logic [15:0]     blk_n;
  logic [27:0]     raw_left;
  logic [27:0]     raw_prod;
  logic [31:0]     crc;
  logic [15:0]     adl_lo;
  logic [15:0]     adl_hi;
  logic [28:0]     blk_x;
  logic [60:0]     blk_plo;
  logic [42:0]     blk_phi;
  logic [43:0]     blk_sum;
  logic [28:0]     blk_count;
  logic [5:0]      item_bytes;
  logic            send;
  logic            advance;
  logic            emit;
  logic [7:0]      byte_v;
  logic            last_v;
  logic            crc_en;
  logic            adl_en;
  logic            raw_en;
  logic            n_load;
  logic            blk_load;
  logic            do_fetch;
  logic            pop;
  logic            bfinal;
  logic [15:0]     n_val;
  logic [31:0]     idat_len;
  logic [31:0]     crc_base;
  logic [31:0]     crc_out;
  logic [7:0]      hdr_b;
  logic [7:0]      raw_b;
  logic [7:0]      blk_b;
  logic [7:0]      trl_b;
  logic [5:0]      crc_off;
  logic [5:0]      len_off;
  logic [15:0]     w16;
  logic [16:0]     lo_sum;
  logic [15:0]     lo_new;
  logic [16:0]     hi_sum;
  logic [15:0]     hi_new;

  assign advance  = !out_valid || out_ready;
  assign q_pop    = pop && advance;
  assign crc_out  = ~crc;
  assign bfinal   = ({12'd0, BLK_MAX} >= raw_left);
  assign n_val    = bfinal ? raw_left[15:0] : BLK_MAX;
  assign idat_len = 32'd6 + {1'b0, blk_count, 2'b00} + {3'b000, blk_count} + {4'd0, raw_left};
  assign crc_off  = idx - HDR_CRC;
  assign len_off  = idx - HDR_LEN;
  // bytes past the per-pixel limit are stepped through but not sent
  assign send     = emit && (item_bytes < ITEM_BYTES_MAX);

  // restart the checksum at the ihdr and idat chunk tags
  assign crc_base = ((state == S_HDR) && (idx == HDR_IHDR || idx == HDR_IDAT)) ? CRC_ONES : crc;

  // raw image size of the frame, kept up to date from the size registers
  assign w16 = {1'b0, dims.width, 1'b0} + {2'b00, dims.width} + 16'd1;
  always_ff @(posedge clk) begin
    raw_prod <= 28'(w16 * dims.height);
  end

  // header bytes
  always_comb begin
    case (idx) inside
      6'd0:           hdr_b = 8'h89;
      6'd1:           hdr_b = 8'h50;
      6'd2:           hdr_b = 8'h4E;
      6'd3:           hdr_b = 8'h47;
      6'd4:           hdr_b = 8'h0D;
      6'd5:           hdr_b = 8'h0A;
      6'd6:           hdr_b = 8'h1A;
      6'd7:           hdr_b = 8'h0A;
      6'd11:          hdr_b = 8'd13;
      6'd12:          hdr_b = 8'h49;
      6'd13:          hdr_b = 8'h48;
      6'd14:          hdr_b = 8'h44;
      6'd15:          hdr_b = 8'h52;
      [6'd16:6'd19]:  hdr_b = be_byte({18'd0, dims.width}, idx[1:0]);
      [6'd20:6'd23]:  hdr_b = be_byte({18'd0, dims.height}, idx[1:0]);
      6'd24:          hdr_b = 8'd8;
      6'd25:          hdr_b = 8'd2;
      [6'd29:6'd32]:  hdr_b = be_byte(crc_out, crc_off[1:0]);
      [6'd33:6'd36]:  hdr_b = be_byte(idat_len, len_off[1:0]);
      6'd37:          hdr_b = 8'h49;
      6'd38:          hdr_b = 8'h44;
      6'd39:          hdr_b = 8'h41;
      6'd40:          hdr_b = 8'h54;
      6'd41:          hdr_b = 8'h78;
      6'd42:          hdr_b = 8'h01;
      default:        hdr_b = 8'h00;
    endcase
  end

  // image bytes: filter byte then red, green, blue
  always_comb begin
    case (raw_idx)
      2'd0:    raw_b = 8'h00;
      2'd1:    raw_b = cur.pixel[23:16];
      2'd2:    raw_b = cur.pixel[15:8];
      default: raw_b = cur.pixel[7:0];
    endcase
  end

  // stored block header after the bfinal byte
  always_comb begin
    case (idx)
      6'd1:    blk_b = blk_n[7:0];
      6'd2:    blk_b = blk_n[15:8];
      6'd3:    blk_b = ~blk_n[7:0];
      default: blk_b = ~blk_n[15:8];
    endcase
  end

  // trailer: adler, idat crc, iend chunk
  always_comb begin
    case (idx) inside
      [6'd0:6'd3]:    trl_b = be_byte({adl_hi, adl_lo}, idx[1:0]);
      [6'd4:6'd7]:    trl_b = be_byte(crc_out, idx[1:0]);
      6'd12:          trl_b = 8'h49;
      6'd13:          trl_b = 8'h45;
      6'd14:          trl_b = 8'h4E;
      6'd15:          trl_b = 8'h44;
      6'd16:          trl_b = 8'hAE;
      6'd17:          trl_b = 8'h42;
      6'd18:          trl_b = 8'h60;
      6'd19:          trl_b = 8'h82;
      default:        trl_b = 8'h00;
    endcase
  end

  // adler-32 step
  always_comb begin
    lo_sum = {1'b0, adl_lo} + {9'd0, raw_b};
    lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    hi_sum = {1'b0, adl_hi} + {1'b0, lo_new};
    hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
  end

  // sequencer
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    raw_idx_next = raw_idx;
    emit         = 1'b0;
    byte_v       = 8'h00;
    last_v       = 1'b0;
    crc_en       = 1'b0;
    adl_en       = 1'b0;
    raw_en       = 1'b0;
    n_load       = 1'b0;
    blk_load     = 1'b0;
    do_fetch     = 1'b0;
    pop          = 1'b0;
    unique case (state)
      S_IDLE: begin
        do_fetch = 1'b1;
      end
      S_HDR: begin
        emit   = 1'b1;
        byte_v = hdr_b;
        crc_en = (idx >= HDR_IHDR && idx <= HDR_IHDR_END) || (idx >= HDR_IDAT);
        if (idx == HDR_LAST) begin
          state_next = S_RAW;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_RAW: begin
        emit   = 1'b1;
        crc_en = 1'b1;
        if (blk_left == '0) begin
          byte_v     = {7'd0, bfinal};
          n_load     = 1'b1;
          state_next = S_BLK;
          idx_next   = 6'd1;
        end else begin
          byte_v = raw_b;
          adl_en = 1'b1;
          raw_en = 1'b1;
          if (raw_idx == 2'd3) begin
            if (cur.eof) begin
              state_next = S_TRL;
              idx_next   = '0;
            end else begin
              do_fetch = 1'b1;
            end
          end else begin
            raw_idx_next = raw_idx + 1'b1;
          end
        end
      end
      S_BLK: begin
        emit   = 1'b1;
        byte_v = blk_b;
        crc_en = 1'b1;
        if (idx == BLK_LAST) begin
          state_next = S_RAW;
          blk_load   = 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_TRL: begin
        emit   = 1'b1;
        byte_v = trl_b;
        crc_en = (idx < TRL_CRC);
        if (idx == TRL_LAST) begin
          last_v   = 1'b1;
          do_fetch = 1'b1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // take the next pixel straight after the current one
    if (do_fetch) begin
      if (!q_empty) begin
        pop          = 1'b1;
        state_next   = q_head.sof ? S_HDR : S_RAW;
        idx_next     = '0;
        raw_idx_next = q_head.sor ? 2'd0 : 2'd1;
      end else begin
        state_next = S_IDLE;
      end
    end
  end

  // control state and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= send;
    end
  end

  // bytes sent for the current pixel, restarted when the next one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      item_bytes <= '0;
    end else if (advance) begin
      if (pop) begin
        item_bytes <= '0;
      end else if (send) begin
        item_bytes <= item_bytes + 1'b1;
      end
    end
  end

  // running sums, counters and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_ONES;
      adl_lo   <= 16'd1;
      adl_hi   <= '0;
      blk_left <= '0;
      raw_left <= '0;
    end else if (advance) begin
      if (crc_en) begin
        crc <= crc_byte(crc_base, byte_v);
      end
      if (state == S_HDR && idx == HDR_INIT) begin
        raw_left <= raw_prod;
        blk_left <= '0;
        adl_lo   <= 16'd1;
        adl_hi   <= '0;
      end
      if (adl_en) begin
        adl_lo <= lo_new;
        adl_hi <= hi_new;
      end
      if (raw_en) begin
        blk_left <= blk_left - 1'b1;
        raw_left <= raw_left - 1'b1;
      end
      if (blk_load) begin
        blk_left <= blk_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_v;
      out_last <= last_v;
      idx      <= idx_next;
      raw_idx  <= raw_idx_next;
      if (n_load) begin
        blk_n <= n_val;
      end
      if (pop) begin
        cur <= q_head;
      end
    end
  end

  // block count by reciprocal multiplication, three register stages,
  // settled long before the idat length goes out
  assign blk_sum = {1'b0, blk_phi} + {15'd0, blk_plo[60:32]};
  always_ff @(posedge clk) begin
    blk_x     <= {1'b0, raw_prod} + {13'd0, BLK_MAX} - 29'd1;
    blk_plo   <= {32'd0, blk_x} * {29'd0, BLK_RECIP[31:0]};
    blk_phi   <= {14'd0, blk_x} * {29'd0, BLK_RECIP[45:32]};
    blk_count <= blk_sum[41:13];
  end
endmodule

// ===== design/png_stored_stream_encoder.sv =====
// top level of the png stored stream encoder
// depends on pse_pkg, pse_front, pse_queue, pse_back
//
// Pixels enter on the s_ stream in raster order, one 24-bit word each
// (red 23:16, green 15:8, blue 7:0). The m_ stream carries the png file one
// byte per word; m_tlast is high on the last byte of the iend chunk.
// The first pixel of a frame brings out 43 header bytes (signature, ihdr
// with crc, idat length and tag, zlib header). Each pixel then gives three
// bytes, a filter byte at each row start and five bytes of stored block
// header whenever a block of up to STORED_BLOCK_MAX bytes opens. The last
// pixel adds 20 trailer bytes (adler-32, idat crc, iend chunk). A pixel sends
// at most 52 bytes, so a 1x1 frame steps through its trailer without sending it.
// The back sequencer moves one byte per cycle while m_tready is high and it is
// not idle; a new pixel enters the four-word queue while bytes of earlier
// ones are still going out. The back sequencer pops a pixel from the queue
// and registers its first byte in the output word. Image size is written on
// the wr_ port between frames; a write while a frame is open is dropped.
// Reset returns the size to 320x240 and empties the queue. When m_tready is
// low the output word holds, the queue fills and s_tready falls once it is full.
module png_stored_stream_encoder #(
  parameter int MAX_WIDTH = pse_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pse_pkg::MAX_HEIGHT_DEF,
  parameter int STORED_BLOCK_MAX = pse_pkg::STORED_BLOCK_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [pse_pkg::DIM_W-1:0] wr_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [23:0]               s_tdata,   // pixel_rgb
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // out_byte
  output logic                      m_tlast    // file_end
);
  pse_pkg::item_t push_item;
  pse_pkg::item_t head_item;
  pse_pkg::dims_t dims;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;

  // accept and classify pixels
  pse_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_pixel(s_tdata),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (push_item),
    .dims    (dims)
  );

  // queue between front and back
  pse_queue #(
    .DEPTH(pse_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (push_item),
    .full (q_full),
    .pop  (q_pop),
    .dout (head_item),
    .empty(q_empty)
  );

  // byte sequencer
  pse_back #(
    .STORED_BLOCK_MAX(STORED_BLOCK_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .q_empty  (q_empty),
    .q_head   (head_item),
    .q_pop    (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_byte (m_tdata),
    .out_last (m_tlast)
  );
endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for png_stored_stream_encoder: pixel frames in, png bytes out
// depends on pse_pkg and the encoder rtl; predicts every file byte and its end flag
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_MAX = pse_pkg::STORED_BLOCK_MAX_DEF;
  localparam int BYTES_PER_PIXEL_MAX = 52;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_PIXELS = 50;
  localparam logic [pse_pkg::DIM_W-1:0] W_MAX = pse_pkg::DIM_W'(pse_pkg::MAX_WIDTH_DEF);
  localparam logic [pse_pkg::DIM_W-1:0] H_MAX = pse_pkg::DIM_W'(pse_pkg::MAX_HEIGHT_DEF);
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [31:0] ADLER_MOD = 32'd65521;
  localparam logic [7:0] ZLIB_CMF = 8'h78;
  localparam logic [7:0] ZLIB_FLG = 8'h01;
  localparam logic [7:0] FILTER_NONE = 8'h00;
  localparam logic [7:0] DEPTH_8 = 8'd8;
  localparam logic [7:0] COLOR_RGB = 8'd2;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  // png stream predictor and byte comparator
  class png_scoreboard;
    logic [pse_pkg::DIM_W-1:0] width, height;
    logic [pse_pkg::DIM_W-1:0] col, row;
    logic [15:0] block_left;
    logic [27:0] raw_left;
    logic [31:0] crc;
    logic [15:0] adler_lo, adler_hi;
    bit          frame_open;
    file_byte_t  bytes_due[$];
    int          step_bytes;
    int          errors, checked, pixels, frames;

    function new();
      width = pse_pkg::WIDTH_RESET;
      height = pse_pkg::HEIGHT_RESET;
      col = '0; row = '0; block_left = '0; raw_left = '0;
      crc = CRC_ONES; adler_lo = 16'd1; adler_hi = '0; frame_open = 0;
      errors = 0; checked = 0; pixels = 0; frames = 0; step_bytes = 0;
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return bytes_due.size();
    endfunction

    // size write, dropped while a frame is open, clamped to 1..max
    function void write_size(logic idx, logic [pse_pkg::DIM_W-1:0] value);
      logic [pse_pkg::DIM_W-1:0] v;
      v = (value == '0) ? pse_pkg::DIM_W'(1) : value;
      if (frame_open) return;
      if (idx == pse_pkg::REG_WIDTH) width = (v > W_MAX) ? W_MAX : v;
      else height = (v > H_MAX) ? H_MAX : v;
    endfunction

    function void put(logic [7:0] b, logic last);
      file_byte_t fb;
      fb.data = b;
      fb.last = last;
      if (step_bytes < BYTES_PER_PIXEL_MAX) bytes_due.push_back(fb);
      step_bytes++;
    endfunction

    function void chunk_byte(logic [7:0] b);
      logic [31:0] c;
      put(b, 1'b0);
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      crc = c;
    endfunction

    function void word32(logic [31:0] v, bit in_crc);
      for (int s = 24; s >= 0; s -= 8)
        if (in_crc) chunk_byte(v[s +: 8]);
        else put(v[s +: 8], 1'b0);
    endfunction

    // image byte, opening a stored block when the last one is used up
    function void image_byte(logic [7:0] b);
      logic [31:0] n, lo, hi;
      if (block_left == '0) begin
        n = ({4'd0, raw_left} > 32'(BLOCK_MAX)) ? 32'(BLOCK_MAX) : {4'd0, raw_left};
        chunk_byte((n == {4'd0, raw_left}) ? 8'd1 : 8'd0);
        chunk_byte(n[7:0]);
        chunk_byte(n[15:8]);
        chunk_byte(~n[7:0]);
        chunk_byte(~n[15:8]);
        block_left = n[15:0];
      end
      chunk_byte(b);
      lo = {16'd0, adler_lo} + {24'd0, b};
      if (lo >= ADLER_MOD) lo = lo - ADLER_MOD;
      hi = {16'd0, adler_hi} + lo;
      if (hi >= ADLER_MOD) hi = hi - ADLER_MOD;
      adler_lo = lo[15:0];
      adler_hi = hi[15:0];
      block_left = block_left - 16'd1;
      raw_left = raw_left - 28'd1;
    endfunction

    function void open_frame();
      logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
      logic [31:0] raw, nblk;
      raw = ({18'd0, width} * 32'd3 + 32'd1) * {18'd0, height};
      nblk = (raw + 32'(BLOCK_MAX) - 32'd1) / 32'(BLOCK_MAX);
      foreach (sig[i]) put(sig[i], 1'b0);
      word32(32'd13, 0);
      crc = CRC_ONES;
      word32(TAG_IHDR, 1);
      word32({18'd0, width}, 1);
      word32({18'd0, height}, 1);
      chunk_byte(DEPTH_8);
      chunk_byte(COLOR_RGB);
      chunk_byte(8'h00);
      chunk_byte(8'h00);
      chunk_byte(8'h00);
      word32(crc ^ CRC_ONES, 0);
      word32(32'd2 + nblk * 32'd5 + raw + 32'd4, 0);
      crc = CRC_ONES;
      word32(TAG_IDAT, 1);
      chunk_byte(ZLIB_CMF);
      chunk_byte(ZLIB_FLG);
      raw_left = raw[27:0];
      block_left = '0; adler_lo = 16'd1; adler_hi = '0;
      col = '0; row = '0; frame_open = 1;
    endfunction

    function void close_frame();
      word32({adler_hi, adler_lo}, 1);
      word32(crc ^ CRC_ONES, 0);
      word32(32'd0, 0);
      word32(TAG_IEND, 0);
      put(8'hAE, 1'b0);
      put(8'h42, 1'b0);
      put(8'h60, 1'b0);
      put(8'h82, 1'b1);
      col = '0; row = '0; block_left = '0; raw_left = '0;
      crc = CRC_ONES; adler_lo = 16'd1; adler_hi = '0; frame_open = 0;
      frames++;
    endfunction

    // accepted pixel: append the bytes it brings out
    function void note_pixel(logic [pse_pkg::PIX_W-1:0] px);
      step_bytes = 0;
      pixels++;
      if (!frame_open) open_frame();
      if (col == '0) image_byte(FILTER_NONE);
      image_byte(px[23:16]);
      image_byte(px[15:8]);
      image_byte(px[7:0]);
      col++;
      if (col >= width) begin
        col = '0;
        row++;
        if (row >= height) close_frame();
      end
    endfunction

    task check_byte(logic [7:0] data, logic last);
      file_byte_t fb;
      if (bytes_due.size() == 0) begin
        report($sformatf("byte %02h with nothing expected", data));
        return;
      end
      fb = bytes_due.pop_front();
      checked++;
      if (data !== fb.data) report($sformatf("byte %02h, expected %02h", data, fb.data));
      if (last !== fb.last) report($sformatf("file_end %b, expected %b", last, fb.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic wr_en = 0;
  logic wr_index = 0;
  logic [pse_pkg::DIM_W-1:0] wr_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [7:0] m_tdata;
  logic m_tlast;

  png_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  png_stored_stream_encoder dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  // receiver: check words, random stalls, long holds on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", STALL_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task send_pixel(logic [23:0] px);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(px);
  endtask

  // stop offering and wait until every byte is out
  task drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_size(logic idx, logic [pse_pkg::DIM_W-1:0] value);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    sb.write_size(idx, value);
    wr_en <= 0;
    @(posedge clk);
  endtask

  task set_size(logic [pse_pkg::DIM_W-1:0] w, logic [pse_pkg::DIM_W-1:0] h);
    drain();
    write_size(pse_pkg::REG_WIDTH, w);
    write_size(pse_pkg::REG_HEIGHT, h);
  endtask

  function logic [23:0] rand_pixel();
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task send_frame(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero sizes are taken as 1x1, each pixel capped at 52 bytes
    set_size(14'd0, 14'd0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    // checkerboard bits, two rows of two
    set_size(14'd2, 14'd2);
    send_pixel(24'hAAAAAA);
    send_pixel(24'h555555);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    // size write inside an open frame is dropped
    set_size(14'd3, 14'd2);
    send_frame(3);
    drain();
    write_size(pse_pkg::REG_WIDTH, 14'd5);
    write_size(pse_pkg::REG_HEIGHT, 14'd1);
    send_frame(3);
    // queue fills while the receiver holds off
    set_size(14'd4, 14'd3);
    hold_req = 300;
    send_frame(12);

    // random frames across sender idle and receiver stall phases
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 85; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 85; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      n = 0;
      while (n < PHASE_PIXELS) begin
        set_size(pse_pkg::DIM_W'($urandom_range(1, 9)), pse_pkg::DIM_W'($urandom_range(1, 6)));
        send_frame(sb.width * sb.height);
        n += sb.width * sb.height;
      end
    end

    // oversized write clamps both sizes; the frame is left open
    send_idle = 0;
    recv_stall = 0;
    set_size(14'h3FFF, 14'h3FFF);
    send_frame(5);
    drain();
    write_size(pse_pkg::REG_WIDTH, 14'd7);
    send_frame(3);

    drain();
    if (sb.pending() > 0) sb.report($sformatf("%0d bytes never came", sb.pending()));
    $display("covered %0d pixels in %0d frames, %0d bytes checked, %0d mismatches",
             sb.pixels, sb.frames, sb.checked, sb.errors);
    $display("frames 1x1 to 9x6 under idles and stalls, dropped writes, clamped 8192x8192 start");
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
